>>> design/trd_pkg.sv
package trd_pkg;

    // default geometry
    localparam int COLUMNS_DEF     = 80;
    localparam int ROWS_DEF        = 25;
    localparam int STACK_DEPTH_DEF = 2000;

    // internal coordinate width, wide enough for every derived point
    localparam int CW = 14;

    // command codes
    localparam logic [3:0] CMD_CLEAR    = 4'd0;
    localparam logic [3:0] CMD_PLOT     = 4'd1;
    localparam logic [3:0] CMD_ERASE    = 4'd2;
    localparam logic [3:0] CMD_HLINE    = 4'd3;
    localparam logic [3:0] CMD_VLINE    = 4'd4;
    localparam logic [3:0] CMD_HARROW   = 4'd5;
    localparam logic [3:0] CMD_VARROW   = 4'd6;
    localparam logic [3:0] CMD_RECT     = 4'd7;
    localparam logic [3:0] CMD_FILLRECT = 4'd8;
    localparam logic [3:0] CMD_LINE     = 4'd9;
    localparam logic [3:0] CMD_FLOOD    = 4'd10;
    localparam logic [3:0] CMD_READ     = 4'd11;

    // characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_DOWN  = 8'h76;
    localparam logic [7:0] CH_UP    = 8'h5E;

    // classified command as it travels through the queue
    typedef struct packed {
        logic [3:0]         op;
        logic signed [11:0] xa;
        logic signed [11:0] ya;
        logic signed [11:0] xb;
        logic signed [11:0] yb;
        logic [7:0]         ch;
        logic               a_on;
        logic               flood_ok;
    } cmd_t;

    function automatic logic signed [CW-1:0] ext12(input logic signed [11:0] v);
        return CW'(v);
    endfunction

endpackage

>>> design/trd_if.sv
interface trd_cmd_if;
    logic               valid;
    logic               ready;
    logic [3:0]         command;
    logic signed [11:0] x_a;
    logic signed [11:0] y_a;
    logic signed [11:0] x_b;
    logic signed [11:0] y_b;
    logic [7:0]         fill_char;

    modport source (output valid, command, x_a, y_a, x_b, y_b, fill_char, input ready);
    modport sink (input valid, command, x_a, y_a, x_b, y_b, fill_char, output ready);
endinterface

interface trd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_char;
    logic       cell_valid;

    modport source (output valid, cell_char, cell_valid, input ready);
    modport sink (input valid, cell_char, cell_valid, output ready);
endinterface

>>> design/text_raster_draw_engine.sv
// Character frame store with a drawing engine.
// cmd: one drawing command per beat (command, two points, fill_char).
// result: exactly one beat per command, in order; cell_char and cell_valid
// carry data only for a read of an on-screen cell, zeros otherwise.
// After reset the store is swept to spaces, one cell per cycle, and
// cmd.ready stays low until the sweep is done.
// A two-entry queue sits behind cmd, so commands are taken while the engine
// works or while a result waits in the output register.
// Work per command, bounded by the single write port of the frame store:
// plot, erase and read handle one cell; lines and rectangle edges go one
// clipped segment at a time; fillrect goes row by row; a general line steps
// along its major axis; clear sweeps every cell; flood handles each filled
// cell with one stack read and four neighbor probes.
// When the result receiver stalls, the engine holds the finished result
// and stops; the queue then fills and cmd.ready drops.
module text_raster_draw_engine #(
    parameter int COLUMNS     = trd_pkg::COLUMNS_DEF,
    parameter int ROWS        = trd_pkg::ROWS_DEF,
    parameter int STACK_DEPTH = trd_pkg::STACK_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    trd_cmd_if.sink   cmd,
    trd_res_if.source result
);

    logic          init_done;
    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    trd_pkg::cmd_t push_data;
    trd_pkg::cmd_t pop_data;

    // accept and classify
    trd_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .cmd       (cmd),
        .init_done (init_done),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (push_data)
    );

    // decoupling queue
    trd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (pop_data)
    );

    // drawing engine
    trd_back #(
        .COLUMNS     (COLUMNS),
        .ROWS        (ROWS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .init_done (init_done),
        .result    (result)
    );

endmodule

>>> design/trd_ram.sv
module trd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/trd_front.sv
module trd_front #(
    parameter int COLUMNS = trd_pkg::COLUMNS_DEF,
    parameter int ROWS    = trd_pkg::ROWS_DEF
) (
    trd_cmd_if.sink         cmd,
    input  logic            init_done,
    input  logic            q_full,
    output logic            q_push,
    output trd_pkg::cmd_t   q_data
);

    logic a_on;

    // point a on screen
    assign a_on = (cmd.x_a >= 12'sd0) && (cmd.y_a >= 12'sd0)
                  && (trd_pkg::ext12(cmd.x_a) < trd_pkg::CW'(COLUMNS))
                  && (trd_pkg::ext12(cmd.y_a) < trd_pkg::CW'(ROWS));

    // accept a beat while the queue has room and the store is initialized
    assign cmd.ready = init_done && !q_full;
    assign q_push    = cmd.valid && cmd.ready;

    // classify the beat
    always_comb
    begin
        q_data.op       = cmd.command;
        q_data.xa       = cmd.x_a;
        q_data.ya       = cmd.y_a;
        q_data.xb       = cmd.x_b;
        q_data.yb       = cmd.y_b;
        q_data.ch       = cmd.fill_char;
        q_data.a_on     = a_on;
        q_data.flood_ok = a_on && (cmd.fill_char != trd_pkg::CH_SPACE);
    end

endmodule

>>> design/trd_queue.sv
module trd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  trd_pkg::cmd_t   push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output trd_pkg::cmd_t   pop_data
);

    trd_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // two-entry queue between front and back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/trd_back.sv
module trd_back #(
    parameter int COLUMNS     = trd_pkg::COLUMNS_DEF,
    parameter int ROWS        = trd_pkg::ROWS_DEF,
    parameter int STACK_DEPTH = trd_pkg::STACK_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  trd_pkg::cmd_t   q_data,
    output logic            q_pop,
    output logic            init_done,
    trd_res_if.source       result
);

    localparam int CW    = trd_pkg::CW;
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(COLUMNS);
    localparam int YW    = $clog2(ROWS);
    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int TW    = $clog2(STACK_DEPTH + 1);
    localparam logic signed [CW-1:0] COLS_S = CW'(COLUMNS);
    localparam logic signed [CW-1:0] ROWS_S = CW'(ROWS);
    localparam logic signed [CW-1:0] ONE    = CW'(1);
    localparam logic signed [CW-1:0] ZERO   = CW'(0);

    // sequencer states
    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_SETUP   = 4'd2;
    localparam logic [3:0] S_RUN     = 4'd3;
    localparam logic [3:0] S_LSET    = 4'd4;
    localparam logic [3:0] S_LINE    = 4'd5;
    localparam logic [3:0] S_FL_RD   = 4'd6;
    localparam logic [3:0] S_FL_CHK  = 4'd7;
    localparam logic [3:0] S_FL_POP  = 4'd8;
    localparam logic [3:0] S_FL_POPD = 4'd9;
    localparam logic [3:0] S_FL_NB   = 4'd10;
    localparam logic [3:0] S_FL_NBD  = 4'd11;
    localparam logic [3:0] S_RD      = 4'd12;
    localparam logic [3:0] S_RDD     = 4'd13;
    localparam logic [3:0] S_DONE    = 4'd14;

    logic [3:0]           state_reg, state_next;
    logic                 init_reg, init_next;
    trd_pkg::cmd_t        cmd_reg, cmd_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [2:0]           phase_reg, phase_next;
    logic signed [CW-1:0] fr_y_reg, fr_y_next;
    logic signed [CW-1:0] wk_pos_reg, wk_pos_next;
    logic signed [CW-1:0] wk_end_reg, wk_end_next;
    logic signed [CW-1:0] wk_f_reg, wk_f_next;
    logic                 wk_v_reg, wk_v_next;
    logic [7:0]           wk_ch_reg, wk_ch_next;
    logic [12:0]          l_i_reg, l_i_next;
    logic [12:0]          l_n_reg, l_n_next;
    logic [12:0]          l_num_reg, l_num_next;
    logic [12:0]          l_q_reg, l_q_next;
    logic [12:0]          l_r_reg, l_r_next;
    logic                 l_xmaj_reg, l_xmaj_next;
    logic                 l_mneg_reg, l_mneg_next;
    logic                 l_mpos_reg, l_mpos_next;
    logic [TW-1:0]        top_reg, top_next;
    logic [XW-1:0]        fx_reg, fx_next;
    logic [YW-1:0]        fy_reg, fy_next;
    logic [1:0]           k_reg, k_next;
    logic [7:0]           res_char_reg, res_char_next;
    logic                 res_cv_reg, res_cv_next;
    logic                 out_valid_reg;
    logic [7:0]           out_char_reg;
    logic                 out_cv_reg;

    logic signed [CW-1:0] xa, ya, xb, yb;
    logic                 seg_has, seg_v, seg_last;
    logic signed [CW-1:0] seg_f, seg_s, seg_e;
    logic [7:0]           seg_ch;
    logic signed [CW-1:0] clip_lo, clip_hi;
    logic                 seg_go;
    logic signed [CW-1:0] dx, dy;
    logic [12:0]          adx, ady;
    logic signed [CW-1:0] l_iv, l_qv, l_off, l_maj, l_min, lx, ly;
    logic                 l_on;
    logic [13:0]          l_rs;
    logic [XW-1:0]        nbx;
    logic [YW-1:0]        nby;
    logic                 nb_ok;
    logic [XW-1:0]        ax;
    logic [YW-1:0]        ay;
    logic [AW-1:0]        cell_addr;
    logic                 f_we;
    logic [AW-1:0]        f_waddr, f_raddr;
    logic [7:0]           f_wdata, f_rdata;
    logic                 s_we;
    logic [XW+YW-1:0]     s_rdata;
    logic [TW-1:0]        top_dec;
    logic                 push_ok;
    logic                 done_fire;

    assign xa = trd_pkg::ext12(cmd_reg.xa);
    assign ya = trd_pkg::ext12(cmd_reg.ya);
    assign xb = trd_pkg::ext12(cmd_reg.xb);
    assign yb = trd_pkg::ext12(cmd_reg.yb);

    // segment of the current drawing phase
    always_comb
    begin
        seg_has  = 1'b1;
        seg_v    = 1'b0;
        seg_last = 1'b1;
        seg_f    = ya;
        seg_s    = xa;
        seg_e    = xb;
        seg_ch   = trd_pkg::CH_DASH;
        case (cmd_reg.op)
            trd_pkg::CMD_PLOT:
            begin
                seg_e  = xa + ONE;
                seg_ch = cmd_reg.ch;
            end
            trd_pkg::CMD_ERASE:
            begin
                seg_e  = xa + ONE;
                seg_ch = trd_pkg::CH_SPACE;
            end
            trd_pkg::CMD_HLINE:
            begin
                seg_ch = trd_pkg::CH_DASH;
            end
            trd_pkg::CMD_VLINE:
            begin
                seg_v  = 1'b1;
                seg_f  = xa;
                seg_s  = ya;
                seg_e  = yb;
                seg_ch = trd_pkg::CH_BAR;
            end
            trd_pkg::CMD_HARROW:
            begin
                if (phase_reg == 3'd0)
                begin
                    seg_last = 1'b0;
                    if (!(xa < xb))
                    begin
                        seg_s = xb + ONE;
                        seg_e = xa + ONE;
                    end
                end
                else
                begin
                    seg_s  = xb;
                    seg_e  = xb + ONE;
                    seg_ch = (xa < xb) ? trd_pkg::CH_GT : trd_pkg::CH_LT;
                end
            end
            trd_pkg::CMD_VARROW:
            begin
                seg_v = 1'b1;
                seg_f = xa;
                if (phase_reg == 3'd0)
                begin
                    seg_last = 1'b0;
                    seg_ch   = trd_pkg::CH_BAR;
                    if (ya < yb)
                    begin
                        seg_s = ya;
                        seg_e = yb;
                    end
                    else
                    begin
                        seg_s = yb + ONE;
                        seg_e = ya + ONE;
                    end
                end
                else
                begin
                    seg_s  = yb;
                    seg_e  = yb + ONE;
                    seg_ch = (ya < yb) ? trd_pkg::CH_DOWN : trd_pkg::CH_UP;
                end
            end
            trd_pkg::CMD_RECT:
            begin
                seg_last = (phase_reg == 3'd7);
                case (phase_reg)
                    3'd0:
                    begin
                        seg_ch = trd_pkg::CH_DASH;
                    end
                    3'd1, 3'd6:
                    begin
                        seg_has = (xb > xa);
                        seg_f   = (phase_reg == 3'd1) ? ya : yb;
                        seg_e   = xa + ONE;
                        seg_ch  = trd_pkg::CH_PLUS;
                    end
                    3'd2, 3'd7:
                    begin
                        seg_has = (xb > xa);
                        seg_f   = (phase_reg == 3'd2) ? ya : yb;
                        seg_s   = xb - ONE;
                        seg_e   = xb;
                        seg_ch  = trd_pkg::CH_PLUS;
                    end
                    3'd3, 3'd4:
                    begin
                        seg_v  = 1'b1;
                        seg_f  = (phase_reg == 3'd3) ? xa : xb - ONE;
                        seg_s  = ya + ONE;
                        seg_e  = yb;
                        seg_ch = trd_pkg::CH_BAR;
                    end
                    default:
                    begin
                        seg_f  = yb;
                        seg_ch = trd_pkg::CH_DASH;
                    end
                endcase
            end
            trd_pkg::CMD_FILLRECT:
            begin
                seg_has  = (fr_y_reg < yb) && (fr_y_reg < ROWS_S);
                seg_last = !seg_has;
                seg_f    = fr_y_reg;
                seg_ch   = cmd_reg.ch;
            end
            default:
            begin
                seg_has = 1'b0;
            end
        endcase
    end

    // clip the segment to the screen
    always_comb
    begin
        clip_lo = (seg_s < ZERO) ? ZERO : seg_s;
        if (seg_v)
        begin
            clip_hi = (seg_e > ROWS_S) ? ROWS_S : seg_e;
            seg_go  = seg_has && (seg_f >= ZERO) && (seg_f < COLS_S) && (clip_lo < clip_hi);
        end
        else
        begin
            clip_hi = (seg_e > COLS_S) ? COLS_S : seg_e;
            seg_go  = seg_has && (seg_f >= ZERO) && (seg_f < ROWS_S) && (clip_lo < clip_hi);
        end
    end

    // line deltas
    always_comb
    begin
        dx  = xb - xa;
        dy  = yb - ya;
        adx = (dx < ZERO) ? 13'(-dx) : 13'(dx);
        ady = (dy < ZERO) ? 13'(-dy) : 13'(dy);
    end

    // current line point, minor offset rounded up or down by direction
    always_comb
    begin
        l_iv  = $signed({1'b0, l_i_reg});
        l_qv  = $signed({1'b0, l_q_reg});
        l_off = l_mpos_reg ? (l_qv + ((l_r_reg != 13'd0) ? ONE : ZERO)) : -l_qv;
        l_maj = (l_xmaj_reg ? xa : ya) + (l_mneg_reg ? -l_iv : l_iv);
        l_min = (l_xmaj_reg ? ya : xa) + l_off;
        lx    = l_xmaj_reg ? l_maj : l_min;
        ly    = l_xmaj_reg ? l_min : l_maj;
        l_on  = (lx >= ZERO) && (lx < COLS_S) && (ly >= ZERO) && (ly < ROWS_S);
        l_rs  = {1'b0, l_r_reg} + {1'b0, l_num_reg};
    end

    // flood neighbor in right, left, down, up order
    always_comb
    begin
        nbx   = fx_reg;
        nby   = fy_reg;
        nb_ok = 1'b0;
        case (k_reg)
            2'd0:
            begin
                nbx   = fx_reg + XW'(1);
                nb_ok = (fx_reg != XW'(COLUMNS - 1));
            end
            2'd1:
            begin
                nbx   = fx_reg - XW'(1);
                nb_ok = (fx_reg != XW'(0));
            end
            2'd2:
            begin
                nby   = fy_reg + YW'(1);
                nb_ok = (fy_reg != YW'(ROWS - 1));
            end
            default:
            begin
                nby   = fy_reg - YW'(1);
                nb_ok = (fy_reg != YW'(0));
            end
        endcase
    end

    // cell address of the active point
    always_comb
    begin
        case (state_reg)
            S_RUN:
            begin
                ax = wk_v_reg ? wk_f_reg[XW-1:0] : wk_pos_reg[XW-1:0];
                ay = wk_v_reg ? wk_pos_reg[YW-1:0] : wk_f_reg[YW-1:0];
            end
            S_LINE:
            begin
                ax = lx[XW-1:0];
                ay = ly[YW-1:0];
            end
            S_FL_NB, S_FL_NBD:
            begin
                ax = nbx;
                ay = nby;
            end
            default:
            begin
                ax = xa[XW-1:0];
                ay = ya[YW-1:0];
            end
        endcase
        cell_addr = AW'(ay * COLUMNS + ax);
    end

    assign top_dec = top_reg - TW'(1);
    assign push_ok = (f_rdata == trd_pkg::CH_SPACE) && (top_reg < TW'(STACK_DEPTH));

    // frame store port control
    always_comb
    begin
        f_we    = 1'b0;
        f_waddr = cell_addr;
        f_wdata = cmd_reg.ch;
        f_raddr = cell_addr;
        s_we    = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                f_we    = 1'b1;
                f_waddr = clr_reg;
                f_wdata = trd_pkg::CH_SPACE;
            end
            S_RUN:
            begin
                f_we    = 1'b1;
                f_wdata = wk_ch_reg;
            end
            S_LINE:
            begin
                f_we = l_on;
            end
            S_FL_CHK:
            begin
                f_we = (f_rdata == trd_pkg::CH_SPACE);
                s_we = f_we;
            end
            S_FL_NBD:
            begin
                f_we = push_ok;
                s_we = push_ok;
            end
            default:
            begin
                f_we = 1'b0;
            end
        endcase
    end

    trd_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_frame (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    trd_ram #(
        .WIDTH (XW + YW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (s_we),
        .waddr (top_reg[SAW-1:0]),
        .wdata ({ay, ax}),
        .raddr (top_dec[SAW-1:0]),
        .rdata (s_rdata)
    );

    assign done_fire = (state_reg == S_DONE) && (!out_valid_reg || result.ready);
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign init_done = init_reg;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        init_next     = init_reg;
        cmd_next      = cmd_reg;
        clr_next      = clr_reg;
        phase_next    = phase_reg;
        fr_y_next     = fr_y_reg;
        wk_pos_next   = wk_pos_reg;
        wk_end_next   = wk_end_reg;
        wk_f_next     = wk_f_reg;
        wk_v_next     = wk_v_reg;
        wk_ch_next    = wk_ch_reg;
        l_i_next      = l_i_reg;
        l_n_next      = l_n_reg;
        l_num_next    = l_num_reg;
        l_q_next      = l_q_reg;
        l_r_next      = l_r_reg;
        l_xmaj_next   = l_xmaj_reg;
        l_mneg_next   = l_mneg_reg;
        l_mpos_next   = l_mpos_reg;
        top_next      = top_reg;
        fx_next       = fx_reg;
        fy_next       = fy_reg;
        k_next        = k_reg;
        res_char_next = res_char_reg;
        res_cv_next   = res_cv_reg;
        case (state_reg)
            S_CLR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(CELLS - 1))
                begin
                    clr_next   = '0;
                    init_next  = 1'b1;
                    state_next = init_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next      = q_data;
                    phase_next    = 3'd0;
                    fr_y_next     = (q_data.ya < 12'sd0) ? ZERO : trd_pkg::ext12(q_data.ya);
                    top_next      = '0;
                    res_char_next = 8'd0;
                    res_cv_next   = 1'b0;
                    case (q_data.op)
                        trd_pkg::CMD_CLEAR:
                        begin
                            state_next = S_CLR;
                        end
                        trd_pkg::CMD_PLOT, trd_pkg::CMD_ERASE, trd_pkg::CMD_HLINE,
                        trd_pkg::CMD_VLINE, trd_pkg::CMD_HARROW, trd_pkg::CMD_VARROW,
                        trd_pkg::CMD_RECT, trd_pkg::CMD_FILLRECT:
                        begin
                            state_next = S_SETUP;
                        end
                        trd_pkg::CMD_LINE:
                        begin
                            state_next = S_LSET;
                        end
                        trd_pkg::CMD_FLOOD:
                        begin
                            state_next = q_data.flood_ok ? S_FL_RD : S_DONE;
                        end
                        trd_pkg::CMD_READ:
                        begin
                            state_next = q_data.a_on ? S_RD : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SETUP, S_RUN:
            begin
                if (state_reg == S_SETUP && seg_go)
                begin
                    wk_pos_next = clip_lo;
                    wk_end_next = clip_hi;
                    wk_f_next   = seg_f;
                    wk_v_next   = seg_v;
                    wk_ch_next  = seg_ch;
                    state_next  = S_RUN;
                end
                else if (state_reg == S_RUN && (wk_pos_reg + ONE) != wk_end_reg)
                begin
                    wk_pos_next = wk_pos_reg + ONE;
                end
                else if (seg_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SETUP;
                    if (cmd_reg.op == trd_pkg::CMD_FILLRECT)
                    begin
                        fr_y_next = fr_y_reg + ONE;
                    end
                    else
                    begin
                        phase_next = phase_reg + 3'd1;
                    end
                end
            end
            S_LSET:
            begin
                l_xmaj_next = (ady <= adx);
                l_n_next    = (ady <= adx) ? adx : ady;
                l_num_next  = (ady <= adx) ? ady : adx;
                l_mneg_next = (ady <= adx) ? (xb < xa) : (yb < ya);
                l_mpos_next = (ady <= adx) ? !(yb < ya) : !(xb < xa);
                l_i_next    = 13'd0;
                l_q_next    = 13'd0;
                l_r_next    = 13'd0;
                state_next  = S_LINE;
            end
            S_LINE:
            begin
                if (l_i_reg == l_n_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    l_i_next = l_i_reg + 13'd1;
                    if (l_rs >= {1'b0, l_n_reg})
                    begin
                        l_r_next = 13'(l_rs - {1'b0, l_n_reg});
                        l_q_next = l_q_reg + 13'd1;
                    end
                    else
                    begin
                        l_r_next = l_rs[12:0];
                    end
                end
            end
            S_FL_RD:
            begin
                state_next = S_FL_CHK;
            end
            S_FL_CHK:
            begin
                if (f_rdata == trd_pkg::CH_SPACE)
                begin
                    top_next   = TW'(1);
                    state_next = S_FL_POP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FL_POP:
            begin
                if (top_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    top_next   = top_dec;
                    state_next = S_FL_POPD;
                end
            end
            S_FL_POPD:
            begin
                fx_next    = s_rdata[XW-1:0];
                fy_next    = s_rdata[XW+YW-1:XW];
                k_next     = 2'd0;
                state_next = S_FL_NB;
            end
            S_FL_NB, S_FL_NBD:
            begin
                if (state_reg == S_FL_NB && nb_ok)
                begin
                    state_next = S_FL_NBD;
                end
                else
                begin
                    if (state_reg == S_FL_NBD && push_ok)
                    begin
                        top_next = top_reg + TW'(1);
                    end
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? S_FL_POP : S_FL_NB;
                end
            end
            S_RD:
            begin
                state_next = S_RDD;
            end
            S_RDD:
            begin
                res_char_next = f_rdata;
                res_cv_next   = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (done_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            init_reg      <= 1'b0;
            clr_reg       <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            clr_reg   <= clr_next;
            top_reg   <= top_next;
            if (done_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        phase_reg    <= phase_next;
        fr_y_reg     <= fr_y_next;
        wk_pos_reg   <= wk_pos_next;
        wk_end_reg   <= wk_end_next;
        wk_f_reg     <= wk_f_next;
        wk_v_reg     <= wk_v_next;
        wk_ch_reg    <= wk_ch_next;
        l_i_reg      <= l_i_next;
        l_n_reg      <= l_n_next;
        l_num_reg    <= l_num_next;
        l_q_reg      <= l_q_next;
        l_r_reg      <= l_r_next;
        l_xmaj_reg   <= l_xmaj_next;
        l_mneg_reg   <= l_mneg_next;
        l_mpos_reg   <= l_mpos_next;
        fx_reg       <= fx_next;
        fy_reg       <= fy_next;
        k_reg        <= k_next;
        res_char_reg <= res_char_next;
        res_cv_reg   <= res_cv_next;
        if (done_fire)
        begin
            out_char_reg <= res_char_reg;
            out_cv_reg   <= res_cv_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.cell_char  = out_char_reg;
    assign result.cell_valid = out_cv_reg;

endmodule
